// ===== design/piu_pkg.sv =====
// Shared types and constants of the power iteration eigenvalue unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package piu_pkg;

	// Widths of the fixed-point values that do not vary with the parameters.
	localparam int PW       = 48;   // product vector entry and result, Q32.16
	localparam int UW       = 18;   // signed unit vector entry, Q2.16
	localparam int MVW      = 17;   // magnitude of a unit vector entry
	localparam int SW       = 24;   // scaled magnitude used for the norm
	localparam int KW       = 5;    // normalizing shift amount
	localparam int QW       = 17;   // quotient bits of the normalizing divide
	localparam int DCW      = 5;    // divide step counter
	localparam int CFG_AW   = 3;    // APB byte address width
	localparam int CFG_DW   = 32;   // APB data width
	localparam int SIZE_W   = 5;    // matrix_size register width
	localparam int ITER_W   = 8;    // iteration_count register width

	localparam logic [DCW-1:0] DIV_STEPS = 5'd17;
	localparam logic [QW-1:0]  ONE_Q16   = 17'h10000;
	localparam logic signed [UW-1:0] ONE_UNIT = 18'sh10000;
	localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

	// Register reset values.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic [ITER_W-1:0] ITER_RESET = 8'd10;

	// Register indexes, taken from paddr[2].
	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_ITER = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store_we;
		logic mac_issue;
		logic mac_rowend;
		logic mac_first;
		logic round_clr;
		logic k_init;
		logic k_step;
		logic sq_issue;
		logic sqrt_init;
		logic sqrt_step;
		logic norm_load;
		logic div_step;
		logic norm_mul;
		logic est_acc;
		logic res_load;
		logic res_zero;
	} piu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic m_zero;
		logic k_done;
		logic sqrt_done;
		logic div_done;
	} piu_status_t;

endpackage

// ===== design/piu_ctrl.sv =====
// Controller of the power iteration eigenvalue unit: load, round and element sequencing.
// Depends on piu_pkg for the command and status structs.
module piu_ctrl import piu_pkg::*; #(
	parameter int MAX_ORDER = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [SIZE_W-1:0]                         matrix_size,
	input  logic [ITER_W-1:0]                         iteration_count,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic                                      last_element,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output piu_cmd_t                                  cmd,
	input  piu_status_t                               status,
	output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]    saddr,
	output logic [$clog2(MAX_ORDER)-1:0]              row,
	output logic [$clog2(MAX_ORDER)-1:0]              col
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW    = $clog2(DEPTH);
	localparam int LCW   = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(MAX_ORDER);
	localparam int NW    = $clog2(MAX_ORDER + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_RSTART, S_MAC, S_MACW, S_KS, S_SQ, S_SQW, S_SQRT,
		S_NRD, S_NLD, S_NDIV, S_NMUL, S_NACC, S_DONE
	} state_t;

	state_t            state_q;
	logic [LCW-1:0]    lc_q;
	logic [NW-1:0]     n_q;
	logic [ITER_W-1:0] rounds_q;
	logic [ITER_W-1:0] r_q;
	logic              first_q;
	logic [IW-1:0]     row_q;
	logic [IW-1:0]     col_q;
	logic [AW-1:0]     flat_q;
	logic              zero_q;
	logic              out_valid_q;

	logic [NW-1:0]     n_cfg;
	logic [ITER_W-1:0] r_cfg;
	logic              accept;
	logic              row_last;
	logic              col_last;
	logic              out_free;

	// Clamp the configured order and round count to their usable ranges.
	always_comb begin
		if (matrix_size == '0) begin
			n_cfg = NW'(1);
		end else if (32'(matrix_size) > MAX_ORDER) begin
			n_cfg = NW'(MAX_ORDER);
		end else begin
			n_cfg = NW'(matrix_size);
		end
		r_cfg = (iteration_count == '0) ? ITER_W'(1) : iteration_count;
	end

	assign in_stall  = (state_q != S_LOAD);
	assign accept    = in_valid && !in_stall;
	assign row_last  = (NW'(row_q) == n_q - NW'(1));
	assign col_last  = (NW'(col_q) == n_q - NW'(1));
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign saddr     = (state_q == S_LOAD) ? lc_q[AW-1:0] : flat_q;
	assign row       = row_q;
	assign col       = col_q;

	// Commands follow from the state and the datapath status.
	always_comb begin
		cmd            = '0;
		cmd.store_we   = accept && (lc_q < LCW'(DEPTH));
		cmd.mac_first  = first_q;
		cmd.mac_rowend = col_last;
		cmd.res_zero   = zero_q;
		unique case (state_q)
			S_RSTART: cmd.round_clr = 1'b1;
			S_MAC:    cmd.mac_issue = 1'b1;
			S_MACW:   cmd.k_init    = !status.busy && !status.m_zero;
			S_KS:     cmd.k_step    = !status.k_done;
			S_SQ:     cmd.sq_issue  = 1'b1;
			S_SQW:    cmd.sqrt_init = !status.busy;
			S_SQRT:   cmd.sqrt_step = !status.sqrt_done;
			S_NLD:    cmd.norm_load = 1'b1;
			S_NDIV:   cmd.div_step  = !status.div_done;
			S_NMUL:   cmd.norm_mul  = 1'b1;
			S_NACC:   cmd.est_acc   = 1'b1;
			S_DONE:   cmd.res_load  = out_free;
			default:  ;
		endcase
	end

	// State and sequencing counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			lc_q        <= '0;
			n_q         <= '0;
			rounds_q    <= '0;
			r_q         <= '0;
			first_q     <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			flat_q      <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.res_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (lc_q < LCW'(DEPTH)) begin
							lc_q <= lc_q + LCW'(1);
						end
						if (last_element) begin
							lc_q     <= '0;
							n_q      <= n_cfg;
							rounds_q <= r_cfg;
							r_q      <= '0;
							first_q  <= 1'b1;
							zero_q   <= 1'b0;
							state_q  <= S_RSTART;
						end
					end
				end
				S_RSTART: begin
					row_q   <= '0;
					col_q   <= '0;
					flat_q  <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					flat_q <= flat_q + AW'(1);
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							state_q <= S_MACW;
						end else begin
							row_q <= row_q + IW'(1);
						end
					end else begin
						col_q <= col_q + IW'(1);
					end
				end
				S_MACW: begin
					if (!status.busy) begin
						if (status.m_zero) begin
							zero_q  <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_KS;
						end
					end
				end
				S_KS: begin
					if (status.k_done) begin
						row_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (row_last) begin
						state_q <= S_SQW;
					end else begin
						row_q <= row_q + IW'(1);
					end
				end
				S_SQW: begin
					if (!status.busy) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (status.sqrt_done) begin
						row_q   <= '0;
						state_q <= S_NRD;
					end
				end
				S_NRD:  state_q <= S_NLD;
				S_NLD:  state_q <= S_NDIV;
				S_NDIV: begin
					if (status.div_done) begin
						state_q <= S_NMUL;
					end
				end
				S_NMUL: state_q <= S_NACC;
				S_NACC: begin
					if (row_last) begin
						if (r_q == rounds_q - ITER_W'(1)) begin
							state_q <= S_DONE;
						end else begin
							r_q     <= r_q + ITER_W'(1);
							first_q <= 1'b0;
							state_q <= S_RSTART;
						end
					end else begin
						row_q   <= row_q + IW'(1);
						state_q <= S_NRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== design/piu_dpath.sv =====
// Datapath of the power iteration eigenvalue unit: matrix store, MAC pipeline,
// shift search, sum of squares, square root, divider and estimate. Depends on piu_pkg.
module piu_dpath import piu_pkg::*; #(
	parameter int MAX_ORDER     = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  piu_cmd_t                                  cmd,
	output piu_status_t                               status,
	input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]    saddr,
	input  logic [$clog2(MAX_ORDER)-1:0]              row,
	input  logic [$clog2(MAX_ORDER)-1:0]              col,
	input  logic signed [ELEMENT_WIDTH-1:0]           matrix_element,
	output logic signed [PW-1:0]                      eigenvalue,
	output logic                                      zero_norm
);

	localparam int EW    = ELEMENT_WIDTH;
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int IW    = $clog2(MAX_ORDER);
	localparam int ACCW  = EW + 2 + IW;
	localparam int SATW  = (ACCW > PW + 1) ? ACCW : PW + 1;
	localparam int SQW   = PW + IW + (IW % 2);
	localparam int HW    = SQW / 2;
	localparam int RW    = HW + 1;
	localparam int ESW   = PW + IW + 1;

	// Storage.
	logic signed [EW-1:0] store_mem [DEPTH];
	logic signed [UW-1:0] unit_mem  [MAX_ORDER];
	logic signed [PW-1:0] prod_mem  [MAX_ORDER];

	logic signed [EW-1:0] a_s1;
	logic signed [UW-1:0] v_rd_q;
	logic signed [PW-1:0] p_rd_q;

	// MAC pipeline.
	logic                  mv1_q, mv2_q;
	logic                  rowend_s1, rowend_s2, first_s1;
	logic [IW-1:0]         row_s1, row_s2;
	logic [EW+MVW-1:0]     prod_s2;
	logic                  neg_s2;
	logic signed [ACCW-1:0] acc_q;
	logic [PW-1:0]         m_q;

	// Norm and estimate.
	logic [PW-1:0]         msh_q;
	logic [KW-1:0]         k_q;
	logic                  sv1_q, sv2_q, sv3_q;
	logic [SW-1:0]         s_s2;
	logic [2*SW-1:0]       sq_s3;
	logic [SQW-1:0]        sum_q;
	logic [SQW-1:0]        srem_q, sres_q, sbit_q;
	logic [PW-1:0]         mp_q;
	logic                  neg_q;
	logic [SW-1:0]         s_q;
	logic [RW-1:0]         drem_q;
	logic [QW-1:0]         dq_q;
	logic [DCW-1:0]        dcnt_q;
	logic [QW+PW-1:0]      nprod_q;
	logic [ESW-1:0]        est_q;
	logic signed [PW-1:0]  eig_q;
	logic                  zero_q;

	// Combinational helpers.
	logic signed [UW-1:0]   v_sel;
	logic [EW-1:0]          a_mag;
	logic [MVW-1:0]         v_mag;
	logic signed [ACCW-1:0] term;
	logic signed [ACCW-1:0] acc_next;
	logic signed [SATW-1:0] acc_x;
	logic signed [PW-1:0]   p_sat;
	logic [PW-1:0]          p_sat_mag;
	logic [PW-1:0]          p_rd_mag;
	logic [SW-1:0]          s_now;
	logic [SQW:0]           sq_trial;
	logic [HW-1:0]          nrm;
	logic                   dbit;
	logic [RW-1:0]          d_trial;
	logic [QW-1:0]          u_val;

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			store_mem[saddr] <= matrix_element;
		end
		a_s1 <= store_mem[saddr];
		if (cmd.norm_mul) begin
			unit_mem[row] <= neg_q ? -UW'(u_val) : UW'(u_val);
		end
		v_rd_q <= unit_mem[col];
		if (mv2_q && rowend_s2) begin
			prod_mem[row_s2] <= p_sat;
		end
		p_rd_q <= prod_mem[row];
	end

	// Multiply term: the first round runs against the all-ones vector.
	always_comb begin
		v_sel     = first_s1 ? ONE_UNIT : v_rd_q;
		a_mag     = a_s1[EW-1] ? EW'(-a_s1) : EW'(a_s1);
		v_mag     = v_sel[UW-1] ? MVW'(-v_sel) : MVW'(v_sel);
		term      = signed'(ACCW'(prod_s2[EW+MVW-1:16]));
		acc_next  = neg_s2 ? acc_q - term : acc_q + term;
		acc_x     = SATW'(acc_next);
		if (acc_x > SATW'(P_MAX)) begin
			p_sat = P_MAX;
		end else if (acc_x < SATW'(P_MIN)) begin
			p_sat = P_MIN;
		end else begin
			p_sat = acc_x[PW-1:0];
		end
		p_sat_mag = p_sat[PW-1] ? PW'(-p_sat) : PW'(p_sat);
		p_rd_mag  = p_rd_q[PW-1] ? PW'(-p_rd_q) : PW'(p_rd_q);
		s_now     = SW'(p_rd_mag >> k_q);
		sq_trial  = (SQW+1)'(sres_q) + (SQW+1)'(sbit_q);
		nrm       = (sres_q[HW-1:0] == '0) ? HW'(1) : sres_q[HW-1:0];
		dbit      = (dcnt_q == DIV_STEPS) ? s_q[0] : 1'b0;
		d_trial   = {drem_q[RW-2:0], dbit};
		u_val     = (dq_q > ONE_Q16) ? ONE_Q16 : dq_q;
	end

	// Pipeline valid tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv1_q  <= 1'b0;
			mv2_q  <= 1'b0;
			sv1_q  <= 1'b0;
			sv2_q  <= 1'b0;
			sv3_q  <= 1'b0;
			dcnt_q <= '0;
		end else begin
			mv1_q <= cmd.mac_issue;
			mv2_q <= mv1_q;
			sv1_q <= cmd.sq_issue;
			sv2_q <= sv1_q;
			sv3_q <= sv2_q;
			if (cmd.norm_load) begin
				dcnt_q <= DIV_STEPS;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DCW'(1);
			end
		end
	end

	// Payload registers of all phases.
	always_ff @(posedge clk) begin
		// Matrix-vector product pipeline.
		rowend_s1 <= cmd.mac_rowend;
		first_s1  <= cmd.mac_first;
		row_s1    <= row;
		rowend_s2 <= rowend_s1;
		row_s2    <= row_s1;
		prod_s2   <= a_mag * v_mag;
		neg_s2    <= a_s1[EW-1] ^ v_sel[UW-1];
		if (cmd.round_clr) begin
			acc_q <= '0;
			m_q   <= '0;
			sum_q <= '0;
			est_q <= '0;
		end else begin
			if (mv2_q) begin
				acc_q <= rowend_s2 ? '0 : acc_next;
				if (rowend_s2 && p_sat_mag > m_q) begin
					m_q <= p_sat_mag;
				end
			end
			if (sv3_q) begin
				sum_q <= sum_q + SQW'(sq_s3);
			end
			if (cmd.est_acc) begin
				est_q <= est_q + ESW'(nprod_q[QW+PW-1:16]);
			end
		end

		// Smallest shift that brings the largest magnitude below 2^24.
		if (cmd.k_init) begin
			msh_q <= m_q;
			k_q   <= '0;
		end else if (cmd.k_step) begin
			msh_q <= msh_q >> 1;
			k_q   <= k_q + KW'(1);
		end

		// Sum of squares pipeline.
		s_s2  <= s_now;
		sq_s3 <= s_s2 * s_s2;

		// Integer square root, one result bit per cycle.
		if (cmd.sqrt_init) begin
			srem_q <= sum_q;
			sres_q <= '0;
			sbit_q <= SQW'(1) << (SQW - 2);
		end else if (cmd.sqrt_step) begin
			if ({1'b0, srem_q} >= sq_trial) begin
				srem_q <= srem_q - sq_trial[SQW-1:0];
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end

		// Restoring divide of the scaled magnitude by the norm.
		if (cmd.norm_load) begin
			mp_q   <= p_rd_mag;
			neg_q  <= p_rd_q[PW-1];
			s_q    <= s_now;
			drem_q <= RW'(s_now >> 1);
			dq_q   <= '0;
		end else if (cmd.div_step) begin
			if (d_trial >= RW'(nrm)) begin
				drem_q <= d_trial - RW'(nrm);
				dq_q   <= {dq_q[QW-2:0], 1'b1};
			end else begin
				drem_q <= d_trial;
				dq_q   <= {dq_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.norm_mul) begin
			nprod_q <= u_val * mp_q;
		end

		// Result register.
		if (cmd.res_load) begin
			zero_q <= cmd.res_zero;
			if (cmd.res_zero) begin
				eig_q <= '0;
			end else if (est_q > ESW'(P_MAX)) begin
				eig_q <= P_MAX;
			end else begin
				eig_q <= est_q[PW-1:0];
			end
		end
	end

	assign status.busy      = mv1_q || mv2_q || sv1_q || sv2_q || sv3_q;
	assign status.m_zero    = (m_q == '0);
	assign status.k_done    = (msh_q[PW-1:SW] == '0);
	assign status.sqrt_done = (sbit_q == '0);
	assign status.div_done  = (dcnt_q == '0);
	assign eigenvalue       = eig_q;
	assign zero_norm        = zero_q;

endmodule

// ===== design/power_iteration_eigenvalue_unit.sv =====
// Power iteration eigenvalue unit, top level: APB registers, controller and datapath.
// The normalizing shift k is at most 24, and the square root takes HW steps (26 at order 16).
// Matrix entries are taken one per cycle while in_stall is low; the single MAC and the bit-serial divider set the rate.
// Reset clears control state and sets matrix_size to 16 and iteration_count to 10.
module power_iteration_eigenvalue_unit import piu_pkg::*; #(
	parameter int MAX_ORDER     = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [CFG_AW-1:0]                 paddr,
	input  logic [CFG_DW-1:0]                 pwdata,
	output logic [CFG_DW-1:0]                 prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ELEMENT_WIDTH-1:0]   matrix_element,
	input  logic                              last_element,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [PW-1:0]              eigenvalue,
	output logic                              zero_norm
);

	localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
	localparam int IW = $clog2(MAX_ORDER);

	logic [SIZE_W-1:0] size_q;
	logic [ITER_W-1:0] iter_q;
	piu_cmd_t          cmd;
	piu_status_t       status;
	logic [AW-1:0]     saddr;
	logic [IW-1:0]     row;
	logic [IW-1:0]     col;

	// Register file: writes complete on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			iter_q <= ITER_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_SIZE: size_q <= pwdata[SIZE_W-1:0];
				REG_ITER: iter_q <= pwdata[ITER_W-1:0];
				default:  ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ITER) ? CFG_DW'(iter_q) : CFG_DW'(size_q);

	piu_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.matrix_size    (size_q),
		.iteration_count(iter_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.last_element   (last_element),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.status         (status),
		.saddr          (saddr),
		.row            (row),
		.col            (col)
	);

	piu_dpath #(
		.MAX_ORDER    (MAX_ORDER),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.saddr         (saddr),
		.row           (row),
		.col           (col),
		.matrix_element(matrix_element),
		.eigenvalue    (eigenvalue),
		.zero_norm     (zero_norm)
	);

	// A zero-norm result carries a zero estimate.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> eigenvalue == '0)
		else $error("zero_norm result with nonzero eigenvalue");

	// The estimate is a sum of magnitudes and never negative.
	a_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !eigenvalue[PW-1])
		else $error("negative eigenvalue estimate");

	// The marked entry starts the computation and closes the input.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_element |=> in_stall)
		else $error("input open after the marked entry");

endmodule
